FILE: hdl/pti_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the polynomial trapezoid integrator.
// No dependencies; every other file of the block imports this package.
package pti_pkg;

    // Polynomial and field geometry
    localparam int MAX_DEGREE = 4;
    localparam int NUM_COEF   = MAX_DEGREE + 1;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    localparam int DEGREE_W   = 3;
    localparam int COUNT_W    = 16;
    localparam int LIMIT_W    = 32;
    localparam int COEF_W     = 32;
    localparam int VALUE_W    = 64;
    localparam int DIFF_W     = LIMIT_W + 1;

    // Step divider: one quotient bit per cycle over the span magnitude
    localparam int DIV_STEPS  = LIMIT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Register file on the APB port
    localparam int APB_DATA_W = 32;
    localparam int NUM_REGS   = 2 + NUM_COEF;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_DEGREE = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_COUNT  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_COEFF0 = REG_IDX_W'(2);

    localparam logic [DEGREE_W-1:0] DEGREE_RESET = DEGREE_W'(4);
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(10000);

    // Saturation limits of the wide fixed-point values
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Configuration as seen by the controller and the datapath
    typedef struct packed {
        logic [DEGREE_W-1:0]              poly_degree;
        logic [COUNT_W-1:0]               interval_count;
        logic [NUM_COEF-1:0][COEF_W-1:0]  coeff;
    } pti_cfg_t;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic                  load_in;
        logic                  div_step;
        logic                  setup;
        logic                  y_init;
        logic                  x_step;
        logic                  mul_start;
        logic                  mul_term;
        logic                  y_add;
        logic [COEF_IDX_W-1:0] coef_sel;
        logic                  keep_first;
        logic                  pair_sum;
        logic                  acc_add;
        logic                  load_out;
    } pti_cmd_t;

    // Clamp the degree to the supported maximum
    function automatic logic [COEF_IDX_W-1:0] eff_degree(input logic [DEGREE_W-1:0] deg);
        logic [COEF_IDX_W-1:0] r;
        if (deg > DEGREE_W'(MAX_DEGREE))
            r = COEF_IDX_W'(MAX_DEGREE);
        else
            r = COEF_IDX_W'(deg);
        return r;
    endfunction

    // A zero interval count runs as a single interval
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] r;
        if (cnt == '0)
            r = COUNT_W'(1);
        else
            r = cnt;
        return r;
    endfunction

endpackage

FILE: hdl/pti_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the integrator: span limits in, integral out.
// Depends on pti_pkg for field widths.
interface pti_in_if;
    import pti_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LIMIT_W-1:0] lower_limit;
    logic signed [LIMIT_W-1:0] upper_limit;

    modport source (output valid, output lower_limit, output upper_limit, input ready);
    modport sink   (input valid, input lower_limit, input upper_limit, output ready);
endinterface

interface pti_out_if;
    import pti_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] integral_value;
    logic                      overflowed;

    modport source (output valid, output integral_value, output overflowed, input ready);
    modport sink   (input valid, input integral_value, input overflowed, output ready);
endinterface

FILE: hdl/polynomial_trapezoid_integrator.sv
`timescale 1ns / 1ps
// Polynomial trapezoid integrator, top level.
// Input channel in_ch carries lower_limit and upper_limit (signed Q16.16); output
// channel out_ch returns integral_value (signed Q56.8, saturated) and overflowed,
// one result per item. Both use valid/ready; an item moves when both are high.
// The APB port sets degree (addr 0x00), interval count (0x04) and coeff_0..4
// (0x08..0x18); pready is always high and registers read back. Write only while idle.
// Each item runs on one shared 32x32 multiplier: a step divide, then d Horner steps
// for the first grid point and d Horner steps plus one term per interval, where d
// is the clamped degree (each Horner step or term is one multiply). One item is
// worked on at a time.
// The finished result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, the following result holds in the
// datapath and no further item is accepted until the output register frees.
// Reset (rst_n low, asynchronous) clears the controller and the output valid and
// loads the register defaults: degree 4, 10000 intervals, all coefficients zero.
// Depends on pti_pkg, pti_if, pti_cfg, pti_mul, pti_dp and pti_ctrl.
module polynomial_trapezoid_integrator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pti_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pti_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pti_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    pti_in_if.sink                         in_ch,
    pti_out_if.source                      out_ch
);
    import pti_pkg::*;

    pti_cfg_t cfg;
    pti_cmd_t cmd;
    logic     mul_done;

    pti_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .mul_done  (mul_done),
        .cmd       (cmd)
    );

    pti_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .lower_limit    (in_ch.lower_limit),
        .upper_limit    (in_ch.upper_limit),
        .mul_done       (mul_done),
        .integral_value (out_ch.integral_value),
        .overflowed     (out_ch.overflowed)
    );

endmodule

FILE: hdl/pti_cfg.sv
`timescale 1ns / 1ps
// APB register file holding degree, interval count and the five coefficients.
// Depends on pti_pkg for the register map and the configuration struct.
module pti_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pti_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pti_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pti_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output pti_pkg::pti_cfg_t             cfg
);
    import pti_pkg::*;

    pti_cfg_t               cfg_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Write registers in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly_degree    <= DEGREE_RESET;
            cfg_reg.interval_count <= COUNT_RESET;
            cfg_reg.coeff          <= '0;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_DEGREE)
                cfg_reg.poly_degree <= pwdata[DEGREE_W-1:0];
            if (reg_idx == REG_COUNT)
                cfg_reg.interval_count <= pwdata[COUNT_W-1:0];
            for (int k = 0; k < NUM_COEF; k++)
            begin
                if (reg_idx == REG_IDX_W'(REG_COEFF0 + k))
                    cfg_reg.coeff[k] <= pwdata[COEF_W-1:0];
            end
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_DEGREE)
            prdata = APB_DATA_W'(cfg_reg.poly_degree);
        if (reg_idx == REG_COUNT)
            prdata = APB_DATA_W'(cfg_reg.interval_count);
        for (int k = 0; k < NUM_COEF; k++)
        begin
            if (reg_idx == REG_IDX_W'(REG_COEFF0 + k))
                prdata = APB_DATA_W'(cfg_reg.coeff[k]);
        end
    end

endmodule

FILE: hdl/pti_mul.sv
`timescale 1ns / 1ps
// Multi-cycle signed multiply with a power-of-two scale, round half away from zero
// and 64-bit saturation; one shared 32x32 multiplier. Depends on pti_pkg.
module pti_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [pti_pkg::VALUE_W-1:0] a,
    input  logic signed [pti_pkg::DIFF_W-1:0]  b,
    input  logic                               term_shift,
    output logic signed [pti_pkg::VALUE_W-1:0] result,
    output logic                               ovf,
    output logic                               done
);
    import pti_pkg::*;

    localparam int HORNER_SHIFT = 16;
    localparam int TERM_SHIFT   = 25;
    localparam int PART_W       = LIMIT_W;
    localparam int PP_W         = 2 * PART_W;
    localparam int PROD_W       = VALUE_W + PART_W;
    localparam int SUM_W        = PROD_W + 1;

    logic [VALUE_W-1:0]          a_mag;
    logic [DIFF_W-1:0]           b_mag;
    logic [VALUE_W-1:0]          ua_reg;
    logic [PART_W-1:0]           ub_reg;
    logic                        neg_reg;
    logic                        term_reg;
    logic [3:0]                  stage_reg;
    logic [PART_W-1:0]           mul_op;
    logic [PP_W-1:0]             pp;
    logic [PP_W-1:0]             plo_reg;
    logic [PP_W-1:0]             phi_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [SUM_W-1:0]            half;
    logic [SUM_W-1:0]            rsum;
    logic [VALUE_W-1:0]          rlo;
    logic                        rhi_nz;
    logic                        sat;
    logic signed [VALUE_W-1:0]   res_reg;
    logic                        ovf_reg;
    logic                        done_reg;

    // Operand magnitudes; |b| always fits one 32-bit part
    assign a_mag = a[VALUE_W-1] ? VALUE_W'(-a) : VALUE_W'(a);
    assign b_mag = b[DIFF_W-1] ? DIFF_W'(-b) : DIFF_W'(b);

    // One multiplier, low half of a first, then high half
    assign mul_op = stage_reg[0] ? ua_reg[PART_W-1:0] : ua_reg[VALUE_W-1:PART_W];
    assign pp     = mul_op * ub_reg;

    // Round, scale and saturate the exact product
    assign half   = term_reg ? (SUM_W'(1) << (TERM_SHIFT - 1))
                             : (SUM_W'(1) << (HORNER_SHIFT - 1));
    assign rsum   = {1'b0, prod_reg} + half;
    assign rlo    = term_reg ? rsum[TERM_SHIFT+VALUE_W-1:TERM_SHIFT]
                             : rsum[HORNER_SHIFT+VALUE_W-1:HORNER_SHIFT];
    assign rhi_nz = term_reg ? (|rsum[SUM_W-1:TERM_SHIFT+VALUE_W])
                             : (|rsum[SUM_W-1:HORNER_SHIFT+VALUE_W]);
    assign sat    = rhi_nz || (rlo[VALUE_W-1] && (!neg_reg || (|rlo[VALUE_W-2:0])));

    // Advance the stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[2:0], start};
            done_reg  <= stage_reg[3];
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg   <= a_mag;
            ub_reg   <= b_mag[PART_W-1:0];
            neg_reg  <= a[VALUE_W-1] ^ b[DIFF_W-1];
            term_reg <= term_shift;
        end
        if (stage_reg[0])
            plo_reg <= pp;
        if (stage_reg[1])
            phi_reg <= pp;
        if (stage_reg[2])
            prod_reg <= {phi_reg, {PART_W{1'b0}}} + {{PART_W{1'b0}}, plo_reg};
        if (stage_reg[3])
        begin
            ovf_reg <= sat;
            if (sat)
                res_reg <= neg_reg ? VALUE_MIN : VALUE_MAX;
            else
                res_reg <= neg_reg ? VALUE_W'(-rlo) : VALUE_W'(rlo);
        end
    end

    assign result = res_reg;
    assign ovf    = ovf_reg;
    assign done   = done_reg;

endmodule

FILE: hdl/pti_dp.sv
`timescale 1ns / 1ps
// Integrator datapath: step divider, grid point, Horner value, pair sum, accumulator
// and the output register. Depends on pti_pkg and pti_mul.
module pti_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pti_pkg::pti_cfg_t                  cfg,
    input  pti_pkg::pti_cmd_t                  cmd,
    input  logic signed [pti_pkg::LIMIT_W-1:0] lower_limit,
    input  logic signed [pti_pkg::LIMIT_W-1:0] upper_limit,
    output logic                               mul_done,
    output logic signed [pti_pkg::VALUE_W-1:0] integral_value,
    output logic                               overflowed
);
    import pti_pkg::*;

    // Saturating 64-bit add; returns {overflow, sum}
    function automatic logic [VALUE_W:0] sat_add(input logic signed [VALUE_W-1:0] x,
                                                 input logic signed [VALUE_W-1:0] y);
        logic signed [VALUE_W-1:0] s;
        logic                      o;
        s = x + y;
        o = (x[VALUE_W-1] == y[VALUE_W-1]) && (s[VALUE_W-1] != x[VALUE_W-1]);
        if (o)
            s = x[VALUE_W-1] ? VALUE_MIN : VALUE_MAX;
        return {o, s};
    endfunction

    logic signed [LIMIT_W-1:0] lower_reg;
    logic signed [LIMIT_W-1:0] x_reg;
    logic                      neg_reg;
    logic [LIMIT_W-1:0]        quo_reg;
    logic [COUNT_W-1:0]        rem_reg;
    logic signed [DIFF_W-1:0]  delta_reg;
    logic signed [VALUE_W-1:0] y_reg;
    logic signed [VALUE_W-1:0] yprev_reg;
    logic signed [VALUE_W-1:0] pair_reg;
    logic signed [VALUE_W-1:0] acc_reg;
    logic                      ovf_reg;
    logic signed [VALUE_W-1:0] integral_reg;
    logic                      overflowed_reg;

    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [COUNT_W:0]          trial;
    logic [COUNT_W:0]          divisor;
    logic                      q_bit;
    logic [COUNT_W:0]          trial_sub;
    logic [DIFF_W-1:0]         quo_ext;
    logic signed [DIFF_W-1:0]  x_sum;
    logic [COEF_W-1:0]         coef_raw;
    logic signed [VALUE_W-1:0] coef_ext;
    logic signed [VALUE_W-1:0] mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [VALUE_W-1:0] mul_res;
    logic                      mul_ovf;
    logic signed [VALUE_W-1:0] ya_val;
    logic                      ya_ovf;
    logic signed [VALUE_W-1:0] pr_val;
    logic                      pr_ovf;
    logic signed [VALUE_W-1:0] ac_val;
    logic                      ac_ovf;

    // Span and its magnitude for the step divider
    assign diff     = {upper_limit[LIMIT_W-1], upper_limit} - {lower_limit[LIMIT_W-1], lower_limit};
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // One restoring divide step
    assign divisor   = {1'b0, eff_count(cfg.interval_count)};
    assign trial     = {rem_reg, quo_reg[LIMIT_W-1]};
    assign q_bit     = (trial >= divisor);
    assign trial_sub = trial - divisor;
    assign quo_ext   = {1'b0, quo_reg};

    // Next grid point; always stays within the span
    assign x_sum = {x_reg[LIMIT_W-1], x_reg} + delta_reg;

    // Coefficient for the current Horner step
    assign coef_raw = cfg.coeff[cmd.coef_sel];
    assign coef_ext = {{(VALUE_W-COEF_W){coef_raw[COEF_W-1]}}, coef_raw};

    // Multiplier operands: Horner step or trapezoid term
    assign mul_a = cmd.mul_term ? pair_reg : y_reg;
    assign mul_b = cmd.mul_term ? delta_reg : {x_reg[LIMIT_W-1], x_reg};

    pti_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.mul_start),
        .a          (mul_a),
        .b          (mul_b),
        .term_shift (cmd.mul_term),
        .result     (mul_res),
        .ovf        (mul_ovf),
        .done       (mul_done)
    );

    assign {ya_ovf, ya_val} = sat_add(mul_res, coef_ext);
    assign {pr_ovf, pr_val} = sat_add(yprev_reg, y_reg);
    assign {ac_ovf, ac_val} = sat_add(acc_reg, mul_res);

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            lower_reg <= lower_limit;
            neg_reg   <= diff[DIFF_W-1];
            quo_reg   <= diff_mag[LIMIT_W-1:0];
            rem_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
            quo_reg <= {quo_reg[LIMIT_W-2:0], q_bit};
        end

        if (cmd.setup)
        begin
            delta_reg <= neg_reg ? DIFF_W'(-quo_ext) : DIFF_W'(quo_ext);
            x_reg     <= lower_reg;
            acc_reg   <= '0;
        end
        else
        begin
            if (cmd.x_step)
                x_reg <= x_sum[LIMIT_W-1:0];
            if (cmd.acc_add)
                acc_reg <= ac_val;
        end

        // Horner value
        if (cmd.y_init)
            y_reg <= coef_ext;
        else if (cmd.y_add)
            y_reg <= ya_val;

        // Point value reuse and pair sum
        if (cmd.keep_first)
            yprev_reg <= y_reg;
        if (cmd.pair_sum)
        begin
            yprev_reg <= y_reg;
            pair_reg  <= pr_val;
        end

        // Sticky saturation flag for the item
        if (cmd.setup)
            ovf_reg <= 1'b0;
        else
            ovf_reg <= ovf_reg | (mul_done & mul_ovf) | (cmd.y_add & ya_ovf)
                     | (cmd.pair_sum & pr_ovf) | (cmd.acc_add & ac_ovf);

        // Output register
        if (cmd.load_out)
        begin
            integral_reg   <= acc_reg;
            overflowed_reg <= ovf_reg;
        end
    end

    assign integral_value = integral_reg;
    assign overflowed     = overflowed_reg;

endmodule

FILE: hdl/pti_ctrl.sv
`timescale 1ns / 1ps
// Integrator controller: sequences divide, Horner steps, trapezoid terms and output.
// Depends on pti_pkg for the command struct and configuration helpers.
module pti_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pti_pkg::pti_cfg_t      cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   mul_done,
    output pti_pkg::pti_cmd_t      cmd
);
    import pti_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SETUP,
        S_H_INIT,
        S_H_MUL,
        S_H_WAIT,
        S_H_DONE,
        S_T_MUL,
        S_T_WAIT,
        S_PUT
    } state_t;

    state_t                 state_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [COUNT_W-1:0]     i_reg;
    logic [COEF_IDX_W-1:0]  k_reg;
    logic                   first_reg;
    logic                   out_valid_reg;
    logic [COEF_IDX_W-1:0]  deg;
    logic [COUNT_W-1:0]     n_int;
    logic                   last_int;
    logic                   out_free;

    assign deg      = eff_degree(cfg.poly_degree);
    assign n_int    = eff_count(cfg.interval_count);
    assign last_int = (i_reg == n_int);
    assign out_free = !out_valid_reg || out_ready;

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the result once taken
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                        state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    i_reg     <= COUNT_W'(1);
                    first_reg <= 1'b1;
                    state_reg <= S_H_INIT;
                end
                S_H_INIT:
                begin
                    k_reg     <= COEF_IDX_W'(1);
                    state_reg <= (deg == '0) ? S_H_DONE : S_H_MUL;
                end
                S_H_MUL:
                begin
                    state_reg <= S_H_WAIT;
                end
                S_H_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (k_reg == deg)
                            state_reg <= S_H_DONE;
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_H_MUL;
                        end
                    end
                end
                S_H_DONE:
                begin
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        state_reg <= S_H_INIT;
                    end
                    else
                        state_reg <= S_T_MUL;
                end
                S_T_MUL:
                begin
                    state_reg <= S_T_WAIT;
                end
                S_T_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (last_int)
                            state_reg <= S_PUT;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_H_INIT;
                        end
                    end
                end
                S_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Decode datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.load_in    = (state_reg == S_IDLE) && in_valid;
        cmd.div_step   = (state_reg == S_DIV);
        cmd.setup      = (state_reg == S_SETUP);
        cmd.y_init     = (state_reg == S_H_INIT);
        cmd.mul_start  = (state_reg == S_H_MUL) || (state_reg == S_T_MUL);
        cmd.mul_term   = (state_reg == S_T_MUL);
        cmd.y_add      = (state_reg == S_H_WAIT) && mul_done;
        cmd.coef_sel   = (state_reg == S_H_INIT) ? '0 : k_reg;
        cmd.keep_first = (state_reg == S_H_DONE) && first_reg;
        cmd.pair_sum   = (state_reg == S_H_DONE) && !first_reg;
        cmd.acc_add    = (state_reg == S_T_WAIT) && mul_done;
        cmd.x_step     = ((state_reg == S_H_DONE) && first_reg)
                       || ((state_reg == S_T_WAIT) && mul_done && !last_int);
        cmd.load_out   = (state_reg == S_PUT) && out_free;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: sim/polynomial_trapezoid_integrator_test.sv
`timescale 1ns / 1ps
// Self-checking test of the polynomial trapezoid integrator: directed span table, then random
// settings and spans checked against a bit-exact fixed-point integral predictor.
// Depends on pti_pkg, pti_if and the polynomial_trapezoid_integrator RTL.
module polynomial_trapezoid_integrator_test;
    import pti_pkg::*;

    localparam int          CYCLE_LIMIT = 4_000_000;
    localparam int          LONG_HOLD   = 8000;
    localparam int          SETTLE      = 500;
    localparam logic [31:0] Q_ONE       = 32'h0001_0000;
    localparam logic [31:0] Q_MIN       = 32'h8000_0000;
    localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;

    typedef logic [0:NUM_COEF-1][COEF_W-1:0] coeff_set_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      ovf;
    } integral_t;

    // One directed span with its register setting; fixed_answer marks a typed-in result
    typedef struct packed {
        logic [DEGREE_W-1:0]       degree;
        logic [COUNT_W-1:0]        count;
        coeff_set_t                coeff;
        logic signed [LIMIT_W-1:0] lower;
        logic signed [LIMIT_W-1:0] upper;
        logic                      fixed_answer;
        logic signed [VALUE_W-1:0] value;
        logic                      ovf;
    } span_case_t;

    localparam int NUM_CASES = 19;
    localparam span_case_t SPAN_CASES [NUM_CASES] = '{
        // constant one over [0, 1], both directions, and a zero interval count
        '{3'd0, 16'd1, '{Q_ONE, 32'd0, 32'd0, 32'd0, 32'd0}, 32'd0, Q_ONE,
          1'b1, 64'sd256, 1'b0},
        '{3'd0, 16'd1, '{Q_ONE, 32'd0, 32'd0, 32'd0, 32'd0}, Q_ONE, 32'd0,
          1'b1, -64'sd256, 1'b0},
        '{3'd0, 16'd0, '{Q_ONE, 32'd0, 32'd0, 32'd0, 32'd0}, 32'd0, Q_ONE,
          1'b1, 64'sd256, 1'b0},
        // equal limits
        '{3'd0, 16'd4, '{Q_ONE, 32'd0, 32'd0, 32'd0, 32'd0}, 32'h0005_0000, 32'h0005_0000,
          1'b1, 64'sd0, 1'b0},
        // each degree, clamped degrees among them
        '{3'd1, 16'd8, '{Q_ONE, 32'd0, 32'd0, 32'd0, 32'd0}, 32'd0, 32'h0002_0000,
          1'b0, 64'sd0, 1'b0},
        '{3'd2, 16'd16, '{Q_ONE, 32'd0, 32'd0, 32'd0, 32'd0}, 32'hFFFF_0000, 32'h0003_0000,
          1'b0, 64'sd0, 1'b0},
        '{3'd3, 16'd5, '{32'h0002_0000, 32'hFFFF_0000, 32'h0001_8000, 32'hFFFE_0000, 32'd0},
          32'hFFFE_0000, 32'h0002_0000, 1'b0, 64'sd0, 1'b0},
        '{3'd4, 16'd3, '{32'h0000_0100, 32'hFFFF_C000, 32'h0003_0000, Q_MIN, Q_MAX},
          32'hFFFF_8000, 32'h0001_8000, 1'b0, 64'sd0, 1'b0},
        '{3'd7, 16'd2, '{32'h0000_8000, Q_ONE, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000},
          32'hFFFF_0000, Q_ONE, 1'b0, 64'sd0, 1'b0},
        '{3'd5, 16'd3, '{32'h0000_8000, Q_ONE, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000},
          Q_ONE, 32'hFFFE_0000, 1'b0, 64'sd0, 1'b0},
        // saturation at both limits of the result
        '{3'd4, 16'd1, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, Q_MIN, Q_MAX,
          1'b1, VALUE_MAX, 1'b1},
        '{3'd4, 16'd1, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, Q_MAX, Q_MIN,
          1'b1, VALUE_MIN, 1'b1},
        // field extremes
        '{3'd0, 16'd1, '{Q_MIN, 32'd0, 32'd0, 32'd0, 32'd0}, Q_MIN, Q_MAX,
          1'b0, 64'sd0, 1'b0},
        '{3'd0, 16'd1, '{Q_MAX, 32'd0, 32'd0, 32'd0, 32'd0}, Q_MAX, Q_MIN,
          1'b0, 64'sd0, 1'b0},
        '{3'd1, 16'd1, '{Q_MIN, Q_MAX, 32'd0, 32'd0, 32'd0}, Q_MIN, Q_MIN,
          1'b0, 64'sd0, 1'b0},
        '{3'd2, 16'd2, '{Q_MIN, 32'd0, Q_MAX, 32'd0, 32'd0}, Q_MIN, Q_MAX,
          1'b0, 64'sd0, 1'b0},
        // span narrower than the interval count, so the step truncates to zero; then an uneven step
        '{3'd3, 16'd7, '{32'hFFFF_8000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0004_0000, 32'd0},
          32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 64'sd0, 1'b0},
        '{3'd4, 16'd9, '{32'd0, 32'd0, 32'd0, 32'd0, 32'h0003_0000}, 32'd0, Q_ONE,
          1'b0, 64'sd0, 1'b0},
        // largest interval count, kept at degree zero to bound run time
        '{3'd0, 16'd65535, '{Q_ONE, 32'd0, 32'd0, 32'd0, 32'd0}, 32'd0, Q_MAX,
          1'b0, 64'sd0, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pti_in_if  in_bus ();
    pti_out_if out_bus ();

    polynomial_trapezoid_integrator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_bus),
        .out_ch  (out_bus)
    );

    // Predictor copy of the register file
    logic [DEGREE_W-1:0] set_degree = DEGREE_RESET;
    logic [COUNT_W-1:0]  set_count  = COUNT_RESET;
    coeff_set_t          set_coeff  = '0;

    integral_t awaited_integrals [$];
    integral_t oldest;
    int        send_idle_pct    = 32;
    int        recv_idle_pct    = 84;
    int        hold_requests    = 0;
    int        mismatches       = 0;
    int        spans_sent       = 0;
    int        integrals_seen   = 0;
    int        settings_applied = 0;
    int        cycles           = 0;

    always #5 clk = ~clk;

    // (a * b) / 2^sh, rounded half away from zero, clipped to 64 bits
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                          input logic signed [63:0] b,
                                                          input int sh, inout bit clipped);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        bit           neg;
        neg  = a[63] ^ b[63];
        ma   = a[63] ? -a : a;
        mb   = b[63] ? -b : b;
        prod = {64'd0, ma} * {64'd0, mb};
        prod = (prod + (128'd1 << (sh - 1))) >> sh;
        if (prod > (neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF))
        begin
            clipped = 1'b1;
            return neg ? VALUE_MIN : VALUE_MAX;
        end
        return neg ? -prod[63:0] : prod[63:0];
    endfunction

    function automatic logic signed [63:0] clip_sum(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    inout bit clipped);
        logic signed [64:0] s;
        s = a + b;
        if (s[64] != s[63])
        begin
            clipped = 1'b1;
            return s[64] ? VALUE_MIN : VALUE_MAX;
        end
        return s[63:0];
    endfunction

    // Horner evaluation at one grid point
    function automatic logic signed [63:0] poly_at(input logic signed [63:0] x, input int deg,
                                                   inout bit clipped);
        logic signed [63:0] y;
        logic signed [31:0] c;
        c = set_coeff[0];
        y = c;
        for (int k = 1; k <= deg; k++)
        begin
            c = set_coeff[k];
            y = scaled_product(y, x, 16, clipped);
            y = clip_sum(y, c, clipped);
        end
        return y;
    endfunction

    // Trapezoid sum over the span under the current setting
    function automatic integral_t predict_integral(input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        longint             n;
        longint             delta;
        int                 deg;
        logic signed [63:0] acc;
        logic signed [63:0] y_prev;
        logic signed [63:0] y_next;
        logic signed [63:0] pair;
        logic signed [63:0] term;
        bit                 clipped;
        integral_t          r;
        n       = (set_count == 0) ? 1 : set_count;
        deg     = (set_degree > MAX_DEGREE) ? MAX_DEGREE : set_degree;
        delta   = (longint'(hi) - longint'(lo)) / n;
        clipped = 1'b0;
        acc     = '0;
        y_prev  = poly_at(lo, deg, clipped);
        for (longint i = 1; i <= n; i++)
        begin
            y_next = poly_at(lo + i * delta, deg, clipped);
            pair   = clip_sum(y_prev, y_next, clipped);
            term   = scaled_product(pair, delta, 25, clipped);
            acc    = clip_sum(acc, term, clipped);
            y_prev = y_next;
        end
        r.value = acc;
        r.ovf   = clipped;
        return r;
    endfunction

    // Small Q16.16 values half the time, else extremes or raw random words
    function automatic logic [31:0] random_fixed();
        case ($urandom_range(0, 9))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2, 3, 4: return $urandom();
            default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        endcase
    endfunction

    // One APB transfer: setup, access, then idle with psel low
    task automatic apb_access(input bit wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        @(negedge clk);
    endtask

    // Hold the input and wait for every awaited integral
    task automatic drain();
        in_bus.valid = 1'b0;
        while (awaited_integrals.size() != 0)
            @(negedge clk);
    endtask

    task automatic apply_setting(input logic [DEGREE_W-1:0] deg, input logic [COUNT_W-1:0] cnt,
                                 input coeff_set_t coeff);
        logic [31:0] unused;
        drain();
        apb_access(1'b1, REG_DEGREE, 32'(deg), unused);
        apb_access(1'b1, REG_COUNT, 32'(cnt), unused);
        for (int k = 0; k < NUM_COEF; k++)
            apb_access(1'b1, REG_IDX_W'(REG_COEFF0 + k), coeff[k], unused);
        set_degree = deg;
        set_count  = cnt;
        set_coeff  = coeff;
        settings_applied++;
    endtask

    // Offer one span; log its integral once the block takes it
    task automatic send_span(input logic [31:0] lo, input logic [31:0] hi, input integral_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_bus.valid = 1'b0;
            @(negedge clk);
        end
        in_bus.valid       = 1'b1;
        in_bus.lower_limit = lo;
        in_bus.upper_limit = hi;
        do
            @(posedge clk);
        while (!in_bus.ready);
        awaited_integrals.push_back(want);
        spans_sent++;
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold when asked
    initial
    begin
        int stall_left;
        int holds_taken;
        stall_left    = 0;
        holds_taken   = 0;
        out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_taken != hold_requests)
            begin
                holds_taken = hold_requests;
                stall_left  = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_bus.ready = 1'b0;
            end
            else
                out_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each delivered integral with the oldest awaited one
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (awaited_integrals.size() == 0)
            begin
                $error("integral_value: expected none, got %0d", out_bus.integral_value);
                mismatches++;
            end
            else
            begin
                oldest = awaited_integrals.pop_front();
                integrals_seen++;
                if (out_bus.integral_value !== oldest.value)
                begin
                    $error("integral_value: expected %0d, got %0d",
                           oldest.value, out_bus.integral_value);
                    mismatches++;
                end
                if (out_bus.overflowed !== oldest.ovf)
                begin
                    $error("overflowed: expected %0b, got %0b", oldest.ovf, out_bus.overflowed);
                    mismatches++;
                end
            end
        end
    end

    // Guard against a hung block
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        span_case_t          row;
        logic [31:0]         rd;
        logic [31:0]         reset_value;
        logic [31:0]         lo;
        logic [31:0]         hi;
        logic [DEGREE_W-1:0] deg;
        logic [COUNT_W-1:0]  cnt;
        coeff_set_t          coeff;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_bus.valid       = 1'b0;
        in_bus.lower_limit = '0;
        in_bus.upper_limit = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Read back the reset values of every register
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_access(1'b0, REG_IDX_W'(i), 32'd0, rd);
            if (i == REG_DEGREE)
                reset_value = 32'(DEGREE_RESET);
            else if (i == REG_COUNT)
                reset_value = 32'(COUNT_RESET);
            else
                reset_value = 32'd0;
            if (rd !== reset_value)
            begin
                $error("register %0d readback: expected %0h, got %0h", i, reset_value, rd);
                mismatches++;
            end
        end

        // Walk the directed table
        for (int i = 0; i < NUM_CASES; i++)
        begin
            row = SPAN_CASES[i];
            if (row.degree != set_degree || row.count != set_count || row.coeff != set_coeff)
                apply_setting(row.degree, row.count, row.coeff);
            if (row.fixed_answer)
                send_span(row.lower, row.upper, '{row.value, row.ovf});
            else
                send_span(row.lower, row.upper, predict_integral(row.lower, row.upper));
        end

        // Random settings and spans, over three stall mixes
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int blk = 0; blk < 3; blk++)
            begin
                deg = $urandom_range(0, 7);
                case ($urandom_range(0, 9))
                    0:       cnt = '0;
                    1, 2:    cnt = $urandom_range(13, 64);
                    default: cnt = $urandom_range(1, 12);
                endcase
                for (int k = 0; k < NUM_COEF; k++)
                    coeff[k] = random_fixed();
                apply_setting(deg, cnt, coeff);
                if (blk == 0)
                begin
                    send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 84 : 0;
                    recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 32 : 0;
                    // back up the block while the sender keeps offering
                    if (phase == 2)
                        hold_requests++;
                end
                for (int j = 0; j < 9; j++)
                begin
                    lo = random_fixed();
                    if ($urandom_range(0, 1))
                        hi = lo + (32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000);
                    else
                        hi = random_fixed();
                    send_span(lo, hi, predict_integral(lo, hi));
                end
            end
        end

        drain();
        repeat (SETTLE) @(negedge clk);
        $display("Sent %0d spans (%0d from the table) under %0d register settings;",
                 spans_sent, NUM_CASES, settings_applied);
        $display("%0d integrals checked against the predictor.", integrals_seen);
        if (mismatches == 0 && awaited_integrals.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
